// ===== design/ofhb_pkg.sv =====
// Shared types and constants for the overwriting frame history buffer.
`default_nettype none

package ofhb_pkg;

   localparam int FRAME_W  = 32;
   localparam int OFFSET_W = 10;
   localparam int COUNT_W  = 7;
   localparam int STORED_W = 11;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   // per-burst fields that every response of one read request carries
   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [STORED_W-1:0] stored;
      logic                empty;
   } burst_meta_type;

   // tag that travels alongside an outstanding store read
   typedef struct packed {
      logic           valid;
      logic           last;
      burst_meta_type meta;
   } rd_tag_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               last;
      burst_meta_type     meta;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== design/ofhb_frame_ram.sv =====
// Frame store: one write port, one read port, registered read data.
`default_nettype none

module ofhb_frame_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] frame_mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= frame_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/ofhb_burst_seq.sv =====
// Read burst sequencer: walks the store addresses of one read request.
`default_nettype none

module ofhb_burst_seq #(
   parameter int AW = 10
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [AW-1:0]                 start_addr,
   input  wire logic [ofhb_pkg::COUNT_W-1:0]  start_left,
   input  wire ofhb_pkg::burst_meta_type      start_meta,
   input  wire logic                          q_pop,
   input  wire logic [1:0]                    q_count,
   output logic                               busy,
   output logic                               rd_en,
   output logic [AW-1:0]                      rd_addr,
   output ofhb_pkg::rd_tag_type               tag
);

   import ofhb_pkg::*;

   logic                busy_ff, busy_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [COUNT_W-1:0]  left_ff, left_in;
   burst_meta_type      meta_ff, meta_in;
   rd_tag_type          tag_ff, tag_in;
   logic [1:0]          occupancy;
   logic                issue;

   // two queue slots; an outstanding read already owns one of them
   assign occupancy = q_count + 2'(tag_ff.valid);
   assign issue     = busy_ff && (occupancy <= (2'd1 + 2'(q_pop)));

   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      left_in = left_ff;
      meta_in = meta_ff;
      if (start) begin
         busy_in = 1'b1;
         addr_in = start_addr;
         left_in = start_left;
         meta_in = start_meta;
      end else if (issue) begin
         addr_in = addr_ff + AW'(1);
         left_in = left_ff - COUNT_W'(1);
         if (left_ff == COUNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
      tag_in.valid = issue;
      tag_in.last  = (left_ff == COUNT_W'(1));
      tag_in.meta  = meta_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         tag_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         tag_ff  <= tag_in;
      end
      addr_ff <= addr_in;
      left_ff <= left_in;
      meta_ff <= meta_in;
   end

   assign busy    = busy_ff;
   assign rd_en   = issue;
   assign rd_addr = addr_ff;
   assign tag     = tag_ff;

endmodule

`default_nettype wire

// ===== design/ofhb_rsp_queue.sv =====
// Two-entry response queue between the store read and the response port.
`default_nettype none

module ofhb_rsp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire ofhb_pkg::rsp_item_type push_item,
   input  wire logic                   pop,
   output logic                        out_valid,
   output ofhb_pkg::rsp_item_type      out_item,
   output logic [1:0]                  count
);

   import ofhb_pkg::*;

   rsp_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign count     = cnt_ff;

endmodule

`default_nettype wire

// ===== design/overwriting_frame_history_buffer_unit.sv =====
// Top level of the overwriting frame history buffer.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  action, frame_in, back_offset, want_frames
//   rsp_      out        rsp_valid/rsp_ready  frame_out, last_frame, frames_returned,
//                                             stored_frames, nothing_read
//
// A write request produces no response; writes can be accepted back to back. A read
// request of N frames occupies the sequencer for N store reads (one for an empty
// read), one store read per cycle through the single read port while the response
// queue has room; the next request is accepted the cycle after the last read is issued.
// Responses leave through a two-entry queue; rsp_ready low stalls the reads and, during
// a burst, new requests. Reset is synchronous; it clears the write position, fill count
// and all control. The frame store has no reset and needs no clearing pass.
`default_nettype none

module overwriting_frame_history_buffer_unit #(
   parameter int DEPTH        = 1024,
   parameter int CHANNELS     = 2,
   parameter int SAMPLE_BYTES = 2,
   parameter int MAX_BURST    = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_action,
   input  wire logic [ofhb_pkg::FRAME_W-1:0]   req_frame_in,
   input  wire logic [ofhb_pkg::OFFSET_W-1:0]  req_back_offset,
   input  wire logic [ofhb_pkg::COUNT_W-1:0]   req_want_frames,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [ofhb_pkg::FRAME_W-1:0]        rsp_frame_out,
   output logic                                rsp_last_frame,
   output logic [ofhb_pkg::COUNT_W-1:0]        rsp_frames_returned,
   output logic [ofhb_pkg::STORED_W-1:0]       rsp_stored_frames,
   output logic                                rsp_nothing_read
);

   import ofhb_pkg::*;

   localparam int AW             = $clog2(DEPTH);
   localparam int CW             = AW + 1;
   localparam int XW             = ((CW > OFFSET_W) ? CW : OFFSET_W) + 1;
   localparam int FRAME_BITS_RAW = CHANNELS * SAMPLE_BYTES * 8;
   localparam int FRAME_BITS     = (FRAME_BITS_RAW > FRAME_W) ? FRAME_W : FRAME_BITS_RAW;

   logic [AW-1:0]         wp_ff, wp_in;
   logic [CW-1:0]         fill_ff, fill_in;

   logic                  req_fire, wr_fire, rd_fire;
   logic [COUNT_W-1:0]    want_c;
   logic [XW-1:0]         offset_x, avail_x, room_x, readable_x, back_x;
   logic                  is_empty;
   logic [AW-1:0]         start_addr;
   logic [COUNT_W-1:0]    start_left;
   burst_meta_type        start_meta;

   logic                  seq_busy;
   logic                  seq_rd_en;
   logic [AW-1:0]         seq_rd_addr;
   rd_tag_type            seq_tag;
   logic [FRAME_BITS-1:0] ram_rdata;

   rsp_item_type          push_item;
   rsp_item_type          out_item;
   logic                  rsp_pop;
   logic [1:0]            q_count;

   assign req_ready = !seq_busy;
   assign req_fire  = req_valid && req_ready;
   assign wr_fire   = req_fire && (req_action == ACTION_WRITE);
   assign rd_fire   = req_fire && (req_action == ACTION_READ);

   // write position and fill count
   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (wr_fire) begin
         wp_in = wp_ff + AW'(1);
         if (fill_ff != CW'(DEPTH)) begin
            fill_in = fill_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

   // read request decode: clamp the count and locate the oldest frame
   always_comb begin
      want_c     = (req_want_frames > COUNT_W'(MAX_BURST)) ? COUNT_W'(MAX_BURST)
                                                           : req_want_frames;
      offset_x   = XW'(req_back_offset);
      avail_x    = XW'(fill_ff);
      is_empty   = (offset_x >= avail_x) || (want_c == '0);
      room_x     = avail_x - offset_x;
      readable_x = (XW'(want_c) < room_x) ? XW'(want_c) : room_x;
      back_x     = offset_x + readable_x;
      start_addr = wp_ff - back_x[AW-1:0];
      // an empty read still takes one slot to carry its single response
      start_left        = is_empty ? COUNT_W'(1) : readable_x[COUNT_W-1:0];
      start_meta.count  = is_empty ? '0 : readable_x[COUNT_W-1:0];
      start_meta.stored = avail_x[STORED_W-1:0];
      start_meta.empty  = is_empty;
   end

   ofhb_frame_ram #(
      .DEPTH (DEPTH),
      .WIDTH (FRAME_BITS),
      .AW    (AW)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_fire),
      .wr_addr (wp_ff),
      .wr_data (req_frame_in[FRAME_BITS-1:0]),
      .rd_en   (seq_rd_en),
      .rd_addr (seq_rd_addr),
      .rd_data (ram_rdata)
   );

   ofhb_burst_seq #(
      .AW (AW)
   ) u_burst_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (rd_fire),
      .start_addr (start_addr),
      .start_left (start_left),
      .start_meta (start_meta),
      .q_pop      (rsp_pop),
      .q_count    (q_count),
      .busy       (seq_busy),
      .rd_en      (seq_rd_en),
      .rd_addr    (seq_rd_addr),
      .tag        (seq_tag)
   );

   always_comb begin
      push_item.frame = seq_tag.meta.empty ? '0 : FRAME_W'(ram_rdata);
      push_item.last  = seq_tag.last;
      push_item.meta  = seq_tag.meta;
   end

   assign rsp_pop = rsp_valid && rsp_ready;

   ofhb_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (seq_tag.valid),
      .push_item (push_item),
      .pop       (rsp_pop),
      .out_valid (rsp_valid),
      .out_item  (out_item),
      .count     (q_count)
   );

   assign rsp_frame_out       = out_item.frame;
   assign rsp_last_frame      = out_item.last;
   assign rsp_frames_returned = out_item.meta.count;
   assign rsp_stored_frames   = out_item.meta.stored;
   assign rsp_nothing_read    = out_item.meta.empty;

   // store write and burst read never share a cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_fire && seq_rd_en))
      else $error("store write and burst read in the same cycle");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_nothing_read) |->
         (rsp_last_frame && (rsp_frames_returned == '0) && (rsp_frame_out == '0)))
      else $error("empty read response malformed");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill count above capacity");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      seq_tag.valid |-> ((q_count != 2'd2) || rsp_pop))
      else $error("response queue overflow");

endmodule

`default_nettype wire

// ===== test/overwriting_frame_history_buffer_unit_tb.sv =====
// Self-checking testbench for the overwriting frame history buffer.
module overwriting_frame_history_buffer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ofhb_pkg::*;

   localparam int DEPTH        = 1024;
   localparam int CHANNELS     = 2;
   localparam int SAMPLE_BYTES = 2;
   localparam int MAX_BURST    = 64;
   localparam int AW           = $clog2(DEPTH);

   localparam int FRAME_BITS_RAW = CHANNELS * SAMPLE_BYTES * 8;
   localparam int FRAME_BITS     = (FRAME_BITS_RAW > 32) ? 32 : FRAME_BITS_RAW;
   localparam logic [FRAME_W-1:0] FRAME_MASK = FRAME_W'((64'd1 << FRAME_BITS) - 64'd1);

   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 32;
   localparam int LIMIT_NS     = 3_000_000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_action;
   logic [FRAME_W-1:0]  req_frame_in;
   logic [OFFSET_W-1:0] req_back_offset;
   logic [COUNT_W-1:0]  req_want_frames;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [FRAME_W-1:0]  rsp_frame_out;
   logic                rsp_last_frame;
   logic [COUNT_W-1:0]  rsp_frames_returned;
   logic [STORED_W-1:0] rsp_stored_frames;
   logic                rsp_nothing_read;

   bit steady;        // both sides run without idle cycles
   bit hold_pending;  // receiver should stall for HOLD_CYCLES

   overwriting_frame_history_buffer_unit #(
      .DEPTH        (DEPTH),
      .CHANNELS     (CHANNELS),
      .SAMPLE_BYTES (SAMPLE_BYTES),
      .MAX_BURST    (MAX_BURST)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_frame_in        (req_frame_in),
      .req_back_offset     (req_back_offset),
      .req_want_frames     (req_want_frames),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_out       (rsp_frame_out),
      .rsp_last_frame      (rsp_last_frame),
      .rsp_frames_returned (rsp_frames_returned),
      .rsp_stored_frames   (rsp_stored_frames),
      .rsp_nothing_read    (rsp_nothing_read)
   );

   class frame_history_scoreboard;
      logic [FRAME_W-1:0] history [DEPTH];
      int unsigned        wr_pos;
      int unsigned        fill;
      rsp_item_type       expected_frames [$];
      int                 errors;
      int                 writes_seen;
      int                 reads_seen;
      int                 empty_reads;
      int                 frames_checked;

      function void note_request(logic action, logic [FRAME_W-1:0] frame,
                                 logic [OFFSET_W-1:0] offset, logic [COUNT_W-1:0] want);
         rsp_item_type item;
         int unsigned  n;
         int unsigned  readable;
         int unsigned  first;
         if (action == ACTION_WRITE) begin
            history[AW'(wr_pos)] = frame & FRAME_MASK;
            wr_pos = (wr_pos + 1) % DEPTH;
            if (fill < DEPTH)
               fill++;
            writes_seen++;
            return;
         end
         reads_seen++;
         n = (want > MAX_BURST) ? MAX_BURST : want;
         item.meta.stored = STORED_W'(fill);
         if (offset >= fill || n == 0) begin
            item.frame      = '0;
            item.last       = 1'b1;
            item.meta.count = '0;
            item.meta.empty = 1'b1;
            expected_frames.push_back(item);
            empty_reads++;
            return;
         end
         readable = (fill - offset < n) ? fill - offset : n;
         // oldest frame of the burst sits offset+readable behind the write position
         first = (wr_pos + 2 * DEPTH - offset - readable) % DEPTH;
         item.meta.count = COUNT_W'(readable);
         item.meta.empty = 1'b0;
         for (int unsigned i = 0; i < readable; i++) begin
            item.frame = history[AW'((first + i) % DEPTH)];
            item.last  = (i + 1 == readable);
            expected_frames.push_back(item);
         end
      endfunction

      function void compare_field(string field, logic [31:0] exp_val, logic [31:0] act_val);
         if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type exp_item;
         if (expected_frames.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual frame 0x%0h",
                     $time, got.frame);
            errors++;
            return;
         end
         exp_item = expected_frames.pop_front();
         frames_checked++;
         compare_field("frame_out",       exp_item.frame, got.frame);
         compare_field("last_frame",      32'(exp_item.last), 32'(got.last));
         compare_field("frames_returned", 32'(exp_item.meta.count), 32'(got.meta.count));
         compare_field("stored_frames",   32'(exp_item.meta.stored), 32'(got.meta.stored));
         compare_field("nothing_read",    32'(exp_item.meta.empty), 32'(got.meta.empty));
      endfunction
   endclass

   frame_history_scoreboard sb;

   always #1 clock = ~clock;

   task automatic send_request(logic action, logic [FRAME_W-1:0] frame,
                               logic [OFFSET_W-1:0] offset, logic [COUNT_W-1:0] want);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= action;
      req_frame_in    <= frame;
      req_back_offset <= offset;
      req_want_frames <= want;
      do @(posedge clock); while (!req_ready);
      sb.note_request(action, frame, offset, want);
   endtask

   // unused fields carry random bits too
   task automatic write_frame(logic [FRAME_W-1:0] frame);
      send_request(ACTION_WRITE, frame, OFFSET_W'($urandom), COUNT_W'($urandom));
   endtask

   task automatic read_burst(int offset, int want);
      send_request(ACTION_READ, $urandom, OFFSET_W'(offset), COUNT_W'(want));
   endtask

   // runs of writes with random frames, each closed by one read request
   task automatic random_traffic(int n_items);
      int sent;
      int run_len;
      int r;
      int offset;
      int want;
      sent = 0;
      while (sent < n_items) begin
         steady = (sent % 100) >= 40 && (sent % 100) < 65;
         r = $urandom_range(0, 99);
         if (r < 10)
            run_len = 0;
         else if (r < 90)
            run_len = $urandom_range(1, 6);
         else
            run_len = $urandom_range(20, 40);
         repeat (run_len) write_frame($urandom);
         r = $urandom_range(0, 99);
         if (r < 5)
            want = 0;
         else if (r < 60)
            want = $urandom_range(1, 8);
         else if (r < 88)
            want = $urandom_range(9, 64);
         else
            want = $urandom_range(65, 127);
         if (sb.fill != 0 && $urandom_range(0, 99) < 80)
            offset = $urandom_range(0, sb.fill - 1);
         else
            offset = $urandom_range(0, DEPTH - 1);
         read_burst(offset, want);
         sent += run_len + 1;
      end
      steady = 1'b0;
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin
      rsp_item_type got;
      int gap;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            gap = HOLD_CYCLES;
         end else begin
            gap = steady ? 0 : $urandom_range(0, 9);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.frame       = rsp_frame_out;
         got.last        = rsp_last_frame;
         got.meta.count  = rsp_frames_returned;
         got.meta.stored = rsp_stored_frames;
         got.meta.empty  = rsp_nothing_read;
         sb.check_response(got);
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("Timeout with %0d responses outstanding", sb.expected_frames.size());
      $display("FAIL");
      $finish;
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = ACTION_WRITE;
      req_frame_in    = '0;
      req_back_offset = '0;
      req_want_frames = '0;
      steady          = 1'b0;
      hold_pending    = 1'b0;
      sb = new;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty store, then a handful of frames
      read_burst(0, 1);
      read_burst(0, 0);
      write_frame(32'hFFFF_FFFF);
      write_frame(32'h0000_0000);
      write_frame(32'hA5A5_5A5A);
      write_frame(32'h5A5A_A5A5);
      read_burst(0, 127);
      read_burst(0, 0);
      read_burst(4, 1);
      read_burst(1023, 64);
      read_burst(1, 2);
      read_burst(3, 1);

      random_traffic(120);

      // a run of back-to-back writes
      steady = 1'b1;
      repeat (24) write_frame($urandom);
      steady = 1'b0;

      read_burst(0, 127);
      read_burst(0, 64);
      read_burst(1023, 64);
      read_burst(1000, 64);
      read_burst(960, 64);
      read_burst(512, 65);

      // long receiver stall while reads keep coming
      hold_pending = 1'b1;
      repeat (12) read_burst($urandom_range(0, DEPTH - 1), $urandom_range(1, 16));

      random_traffic(140);

      req_valid <= 1'b0;
      while (sb.expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d write and %0d read requests (%0d empty reads), %0d frames checked",
               sb.writes_seen, sb.reads_seen, sb.empty_reads, sb.frames_checked);
      $display("Bursts clamped at %0d frames, back-to-back write runs, one %0d-cycle stall",
               MAX_BURST, HOLD_CYCLES);
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/ofhb_pkg.sv
design/ofhb_frame_ram.sv
design/ofhb_burst_seq.sv
design/ofhb_rsp_queue.sv
design/overwriting_frame_history_buffer_unit.sv
test/overwriting_frame_history_buffer_unit_tb.sv
